// ----- rtl/assert_macros.svh -----
// Assertion shorthands for the bound assertion checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that expr holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/pwar_pkg.sv -----
package pwar_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_STA,
        ST_SMP,
        ST_DIV,
        ST_OUT
    } state_t;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    localparam logic [1:0] CFG_STATION_COUNT   = 2'd0;
    localparam logic [1:0] CFG_INV_VELOCITY    = 2'd1;
    localparam logic [1:0] CFG_SAMPLE_INTERVAL = 2'd2;
    localparam logic [1:0] CFG_SAMPLE_COUNT    = 2'd3;

    localparam logic [7:0]  RST_STATION_COUNT   = 8'd1;
    localparam logic [23:0] RST_INV_VELOCITY    = 24'd8388608;
    localparam logic [31:0] RST_SAMPLE_INTERVAL = 32'd42949673;
    localparam logic [12:0] RST_SAMPLE_COUNT    = 13'd1;

    localparam logic [15:0] FULL_SCALE = 16'd32768;

    // CORDIC datapath
    localparam int CORDIC_STEPS = 16;
    localparam int CW           = 34;
    localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

    // atan(2^-i) in Q0.32 cycles
    function automatic logic signed [CW-1:0] arc(input int i);
        logic signed [CW-1:0] r;
        case (i)
            0:       r = 34'sd536870912;
            1:       r = 34'sd316933406;
            2:       r = 34'sd167458907;
            3:       r = 34'sd85004756;
            4:       r = 34'sd42667331;
            5:       r = 34'sd21354465;
            6:       r = 34'sd10679838;
            7:       r = 34'sd5340245;
            8:       r = 34'sd2670163;
            9:       r = 34'sd1335087;
            10:      r = 34'sd667544;
            11:      r = 34'sd333772;
            12:      r = 34'sd166886;
            13:      r = 34'sd83443;
            14:      r = 34'sd41722;
            default: r = 34'sd20861;
        endcase
        return r;
    endfunction

    // round half up from Q.30 to Q1.15 and clamp to +-1.0
    function automatic logic signed [16:0] to_q15(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] s;
        logic signed [CW-1:0] r;
        logic signed [16:0]   q;
        s = v + 34'sd16384;
        r = s >>> 15;
        if (r > 34'sd32768)
            q = 17'sd32768;
        else if (r < -34'sd32768)
            q = -17'sd32768;
        else
            q = r[16:0];
        return q;
    endfunction

endpackage

// ----- rtl/pwar_ram.sv -----
module pwar_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/pwar_phase.sv -----
module pwar_phase (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid_in,
    input  logic signed [48:0] term,
    input  logic signed [23:0] dist_in,
    output logic               valid_out,
    output logic [31:0]        angle
);

    // term split into a signed high part and an unsigned low 26 bits;
    // only the low 52 bits of term*dist_in matter
    logic               v1_reg;
    logic signed [50:0] lo_reg;
    logic [25:0]        hi_reg;
    logic signed [50:0] lo_prod;
    logic signed [46:0] hi_prod;
    logic [51:0]        ph;

    assign lo_prod = $signed({1'b0, term[25:0]}) * dist_in;
    assign hi_prod = $signed(term[48:26]) * dist_in;
    assign ph = {hi_reg, 26'd0} + 52'($signed(lo_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            valid_out <= 1'b0;
        end
        else
        begin
            v1_reg    <= valid_in;
            valid_out <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_prod;
        hi_reg <= hi_prod[25:0];
        angle  <= ph[51:20];
    end

endmodule

// ----- rtl/pwar_cordic.sv -----
module pwar_cordic (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid_in,
    input  logic [31:0]        angle,
    output logic               valid_out,
    output logic signed [16:0] sin_q,
    output logic signed [16:0] cos_q
);

    localparam int N  = pwar_pkg::CORDIC_STEPS;
    localparam int CW = pwar_pkg::CW;

    logic signed [CW-1:0] x_reg [0:N];
    logic signed [CW-1:0] y_reg [0:N];
    logic signed [CW-1:0] z_reg [0:N];
    logic                 neg_reg [0:N];
    logic                 v_reg [0:N];

    logic [31:0] shifted;
    logic [31:0] folded;
    logic        fold;
    logic signed [CW-1:0] xf;
    logic signed [CW-1:0] yf;

    // fold the angle into the right half plane, negate at the end
    assign shifted = angle + 32'h4000_0000;
    assign fold    = shifted[31];
    assign folded  = fold ? (angle + 32'h8000_0000) : angle;
    assign xf      = neg_reg[N] ? -x_reg[N] : x_reg[N];
    assign yf      = neg_reg[N] ? -y_reg[N] : y_reg[N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0]  <= 1'b0;
            valid_out <= 1'b0;
        end
        else
        begin
            v_reg[0]  <= valid_in;
            valid_out <= v_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]   <= pwar_pkg::CORDIC_X0;
        y_reg[0]   <= '0;
        z_reg[0]   <= CW'($signed(folded));
        neg_reg[0] <= fold;
        sin_q      <= pwar_pkg::to_q15(yf);
        cos_q      <= pwar_pkg::to_q15(xf);
    end

    for (genvar i = 0; i < N; i++)
    begin : g_step
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            neg_reg[i+1] <= neg_reg[i];
            if (!z_reg[i][CW-1])
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - pwar_pkg::arc(i);
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + pwar_pkg::arc(i);
            end
        end
    end

endmodule

// ----- rtl/pwar_div.sv -----
module pwar_div #(
    parameter int QW = 27,
    parameter int NW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [QW-1:0] dividend,
    input  logic [NW-1:0] divisor,
    output logic          done,
    output logic [QW-1:0] quotient
);

    localparam int KW = $clog2(QW + 1);

    logic          busy_reg;
    logic [KW-1:0] cnt_reg;
    logic [NW-1:0] rem_reg;
    logic [NW-1:0] den_reg;
    logic [NW:0]   trial;
    logic          fits;

    // one quotient bit per cycle, restoring
    assign trial = {rem_reg, quotient[QW-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= KW'(QW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == KW'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            den_reg  <= divisor;
            quotient <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? NW'(trial - {1'b0, den_reg}) : trial[NW-1:0];
            quotient <= {quotient[QW-2:0], fits};
        end
    end

endmodule

// ----- rtl/plane_wave_array_response.sv -----
// Sequence: an accepted compute transaction goes through setup, a station pass,
//   a sample pass, a divide and an output step before its result comes out; the
//   station pass scales with the clamped station count and the sample pass with
//   the clamped sample count. A load transaction writes the table and gives no result.
// Throughput: one compute transaction at a time; input stalls until it is done.
// Reset: config to defaults, running max 0, running min full scale; table undefined.
module plane_wave_array_response #(
    parameter int MAX_STATIONS = 128,
    parameter int MAX_SAMPLES  = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    // input transactions
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  logic [6:0]         station_index,
    input  logic signed [23:0] distance,
    input  logic signed [23:0] wavenumber,
    input  logic [23:0]        frequency,
    // result transactions
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        amplitude,
    output logic [15:0]        grid_max,
    output logic [15:0]        grid_min,
    // configuration writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int AW   = $clog2(MAX_STATIONS);
    localparam int NW   = $clog2(MAX_STATIONS + 1);
    localparam int SW   = $clog2(MAX_SAMPLES + 1);
    localparam int SUMW = AW + 17;   // sum of n values in [-1, 1] Q1.15
    localparam int PW   = SUMW + 17; // sine times sum
    localparam int BW   = PW + 1;    // beam value
    localparam int QW   = BW - 15;   // beam scaled down by full scale

    // configuration registers
    logic [7:0]  station_count_reg;
    logic [23:0] inv_velocity_reg;
    logic [31:0] sample_interval_reg;
    logic [12:0] sample_count_reg;

    pwar_pkg::state_t state_reg, state_next;

    logic [23:0]        kabs_reg;
    logic [23:0]        freq_reg;
    logic signed [48:0] term_reg;
    logic [47:0]        step_reg;
    logic [47:0]        acc_reg;

    logic [NW-1:0] sta_iss_reg;
    logic [NW-1:0] sta_rcv_reg;
    logic [SW-1:0] smp_iss_reg;
    logic [SW-1:0] smp_rcv_reg;

    logic signed [SUMW-1:0] sum_s_reg;
    logic signed [SUMW-1:0] sum_c_reg;
    logic signed [PW-1:0]   m1_reg;
    logic signed [PW-1:0]   m2_reg;
    logic                   m_v_reg;
    logic [BW-1:0]          b_reg;
    logic                   b_v_reg;
    logic [BW-1:0]          best_reg;

    logic [15:0] amp_reg;
    logic [15:0] running_max_reg;
    logic [15:0] running_min_reg;
    logic        out_valid_reg;
    logic [15:0] amplitude_reg;
    logic [15:0] grid_max_reg;
    logic [15:0] grid_min_reg;

    logic [31:0]   n_wide;
    logic [31:0]   ns_wide;
    logic [NW-1:0] n_eff;
    logic [SW-1:0] ns_eff;
    logic          in_acc;
    logic [31:0]   idx_ext;
    logic          ram_we;
    logic [23:0]   ram_rdata;
    logic          sta_issue;
    logic          smp_issue;
    logic          rd_v_reg;
    logic          ph_valid;
    logic [31:0]   ph_angle;
    logic          cd_valid_in;
    logic [31:0]   cd_angle;
    logic          cd_valid;
    logic signed [16:0] cd_sin;
    logic signed [16:0] cd_cos;
    logic signed [BW-1:0] b_sum;
    logic          div_start;
    logic          div_done;
    logic [QW-1:0] quot;
    logic          out_load;
    logic [47:0]   tprod;
    logic [55:0]   sprod;

    // clamp the counts into range; zero acts as one
    always_comb
    begin
        n_wide = 32'(station_count_reg);
        if (station_count_reg == 8'd0)
            n_wide = 32'd1;
        else if (n_wide > 32'(MAX_STATIONS))
            n_wide = 32'(MAX_STATIONS);
        ns_wide = 32'(sample_count_reg);
        if (sample_count_reg == 13'd0)
            ns_wide = 32'd1;
        else if (ns_wide > 32'(MAX_SAMPLES))
            ns_wide = 32'(MAX_SAMPLES);
    end
    assign n_eff  = n_wide[NW-1:0];
    assign ns_eff = ns_wide[SW-1:0];

    assign cfg_ready = 1'b1;
    assign in_stall  = state_reg != pwar_pkg::ST_IDLE;
    assign in_acc    = in_valid && !in_stall;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_count_reg   <= pwar_pkg::RST_STATION_COUNT;
            inv_velocity_reg    <= pwar_pkg::RST_INV_VELOCITY;
            sample_interval_reg <= pwar_pkg::RST_SAMPLE_INTERVAL;
            sample_count_reg    <= pwar_pkg::RST_SAMPLE_COUNT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pwar_pkg::CFG_STATION_COUNT:   station_count_reg   <= cfg_data[7:0];
                pwar_pkg::CFG_INV_VELOCITY:    inv_velocity_reg    <= cfg_data[23:0];
                pwar_pkg::CFG_SAMPLE_INTERVAL: sample_interval_reg <= cfg_data;
                pwar_pkg::CFG_SAMPLE_COUNT:    sample_count_reg    <= cfg_data[12:0];
                default:                       ;
            endcase
        end
    end

    // distance table: loads write it while idle, the station pass reads it
    assign idx_ext = 32'(station_index);
    assign ram_we  = in_acc && (op == pwar_pkg::OP_LOAD) && (idx_ext < 32'(MAX_STATIONS));

    pwar_ram #(
        .WIDTH (24),
        .DEPTH (MAX_STATIONS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_ext[AW-1:0]),
        .wdata (distance),
        .raddr (sta_iss_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign sta_issue = (state_reg == pwar_pkg::ST_STA) && (sta_iss_reg < n_eff);
    assign smp_issue = (state_reg == pwar_pkg::ST_SMP) && (smp_iss_reg < ns_eff);

    pwar_phase u_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (rd_v_reg),
        .term      (term_reg),
        .dist_in   ($signed(ram_rdata)),
        .valid_out (ph_valid),
        .angle     (ph_angle)
    );

    // share the CORDIC: station phases first, then sample phases
    assign cd_valid_in = (state_reg == pwar_pkg::ST_STA) ? ph_valid : smp_issue;
    assign cd_angle    = (state_reg == pwar_pkg::ST_STA) ? ph_angle : acc_reg[47:16];

    pwar_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (cd_valid_in),
        .angle     (cd_angle),
        .valid_out (cd_valid),
        .sin_q     (cd_sin),
        .cos_q     (cd_cos)
    );

    assign b_sum = BW'(m1_reg) + BW'(m2_reg);

    assign div_start = (state_reg == pwar_pkg::ST_SMP) && (smp_rcv_reg == ns_eff);

    pwar_div #(
        .QW (QW),
        .NW (NW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (best_reg[BW-1:15]),
        .divisor  (n_eff),
        .done     (div_done),
        .quotient (quot)
    );

    assign out_load = (state_reg == pwar_pkg::ST_OUT) && (!out_valid_reg || !out_stall);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pwar_pkg::ST_IDLE:
                if (in_acc && (op == pwar_pkg::OP_COMPUTE))
                    state_next = pwar_pkg::ST_SETUP;
            pwar_pkg::ST_SETUP:
                state_next = pwar_pkg::ST_STA;
            pwar_pkg::ST_STA:
                if (sta_rcv_reg == n_eff)
                    state_next = pwar_pkg::ST_SMP;
            pwar_pkg::ST_SMP:
                if (div_start)
                    state_next = pwar_pkg::ST_DIV;
            pwar_pkg::ST_DIV:
                if (div_done)
                    state_next = pwar_pkg::ST_OUT;
            pwar_pkg::ST_OUT:
                if (out_load)
                    state_next = pwar_pkg::ST_IDLE;
            default:
                state_next = pwar_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pwar_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // control counters and valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sta_iss_reg     <= '0;
            sta_rcv_reg     <= '0;
            smp_iss_reg     <= '0;
            smp_rcv_reg     <= '0;
            rd_v_reg        <= 1'b0;
            m_v_reg         <= 1'b0;
            b_v_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            running_max_reg <= '0;
            running_min_reg <= pwar_pkg::FULL_SCALE;
        end
        else
        begin
            rd_v_reg <= sta_issue;
            m_v_reg  <= cd_valid && (state_reg == pwar_pkg::ST_SMP);
            b_v_reg  <= m_v_reg;
            if (state_reg == pwar_pkg::ST_SETUP)
            begin
                sta_iss_reg <= '0;
                sta_rcv_reg <= '0;
                smp_iss_reg <= '0;
                smp_rcv_reg <= '0;
            end
            else
            begin
                if (sta_issue)
                    sta_iss_reg <= sta_iss_reg + 1'b1;
                if (cd_valid && (state_reg == pwar_pkg::ST_STA))
                    sta_rcv_reg <= sta_rcv_reg + 1'b1;
                if (smp_issue)
                    smp_iss_reg <= smp_iss_reg + 1'b1;
                if (b_v_reg)
                    smp_rcv_reg <= smp_rcv_reg + 1'b1;
            end
            // drop the result once taken, unless a new one replaces it
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                if (amp_reg > running_max_reg)
                    running_max_reg <= amp_reg;
                if (amp_reg < running_min_reg)
                    running_min_reg <= amp_reg;
            end
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign tprod = freq_reg * inv_velocity_reg;
    assign sprod = freq_reg * sample_interval_reg;

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            kabs_reg <= wavenumber[23] ? 24'(-wavenumber) : wavenumber;
            freq_reg <= frequency;
        end
        if (state_reg == pwar_pkg::ST_SETUP)
        begin
            term_reg  <= $signed({1'b0, tprod}) - $signed({5'd0, kabs_reg, 20'd0});
            step_reg  <= sprod[47:0];
            acc_reg   <= '0;
            sum_s_reg <= '0;
            sum_c_reg <= '0;
            best_reg  <= '0;
        end
        else
        begin
            if (smp_issue)
                acc_reg <= acc_reg + step_reg;
            if (cd_valid && (state_reg == pwar_pkg::ST_STA))
            begin
                sum_s_reg <= sum_s_reg + SUMW'(cd_sin);
                sum_c_reg <= sum_c_reg + SUMW'(cd_cos);
            end
            if (b_v_reg && (b_reg > best_reg))
                best_reg <= b_reg;
        end
        // beam value: sin(wt)*C + cos(wt)*S, then its magnitude
        m1_reg <= cd_sin * sum_c_reg;
        m2_reg <= cd_cos * sum_s_reg;
        b_reg  <= b_sum[BW-1] ? BW'(-b_sum) : BW'(b_sum);
        if (div_done)
            amp_reg <= (quot > QW'(pwar_pkg::FULL_SCALE)) ? pwar_pkg::FULL_SCALE : quot[15:0];
        if (out_load)
        begin
            amplitude_reg <= amp_reg;
            grid_max_reg  <= (amp_reg > running_max_reg) ? amp_reg : running_max_reg;
            grid_min_reg  <= (amp_reg < running_min_reg) ? amp_reg : running_min_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign amplitude = amplitude_reg;
    assign grid_max  = grid_max_reg;
    assign grid_min  = grid_min_reg;

endmodule

// ----- rtl/pwar_checker.sv -----
`include "assert_macros.svh"

module pwar_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] amplitude,
    input logic [15:0] grid_max,
    input logic [15:0] grid_min
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(amplitude))
    `ASSERT_ALWAYS(a_amp_range, clk, rst_n, !out_valid || (amplitude <= 16'd32768))
    `ASSERT_ALWAYS(a_amp_bounds, clk, rst_n, !out_valid || ((grid_min <= amplitude) && (amplitude <= grid_max)))
    `ASSERT_NEXT(a_max_grows, clk, rst_n, out_valid && !out_stall, !out_valid || (grid_max >= $past(grid_max)))

endmodule

bind plane_wave_array_response pwar_checker u_pwar_checker (.*);

// ----- test/plane_wave_array_response_checker.sv -----
module plane_wave_array_response_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               op,
    input  logic [6:0]         station_index,
    input  logic signed [23:0] distance,
    input  logic signed [23:0] wavenumber,
    input  logic [23:0]        frequency,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [15:0]        amplitude,
    input  logic [15:0]        grid_max,
    input  logic [15:0]        grid_min,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic [15:0] amp;
        logic [15:0] peak;
        logic [15:0] floor_amp;
    } beam_t;

    localparam longint ATAN_TAB [16] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861
    };

    logic signed [23:0] dist_tab [128];
    logic [7:0]  n_sta;
    logic [23:0] slowness;
    logic [31:0] dt;
    logic [12:0] n_smp;
    logic [15:0] peak_amp;
    logic [15:0] floor_amp;
    beam_t       beam_q [$];

    function automatic longint round_q15(input longint v);
        longint r;
        r = (v + 16384) >>> 15;
        if (r > 32768)
            r = 32768;
        if (r < -32768)
            r = -32768;
        return r;
    endfunction

    // angle in Q0.32 cycles
    function automatic void sincos(input logic [31:0] ang, output longint sn,
                                   output longint cs);
        longint x, y, z, nx, ny;
        logic [31:0] a;
        logic [31:0] probe;
        bit flip;
        a = ang;
        flip = 0;
        probe = a + 32'h4000_0000;
        if (probe >= 32'h8000_0000)
        begin
            a = a + 32'h8000_0000;
            flip = 1;
        end
        z = {{32{a[31]}}, a};
        x = 652032874;
        y = 0;
        for (int i = 0; i < 16; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z = z - ATAN_TAB[i];
            end
            else
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z = z + ATAN_TAB[i];
            end
            x = nx;
            y = ny;
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        sn = round_q15(y);
        cs = round_q15(x);
    endfunction

    function automatic logic [15:0] beam_peak(input logic signed [23:0] k_in,
                                              input logic [23:0] f_in);
        longint n, ns, kk, fr, term, ph, dd, sum_s, sum_c, sn, cs, b, best;
        longint step, acc, q;
        logic [63:0] phv;
        n = (n_sta == 0) ? 1 : (n_sta > 128) ? 128 : n_sta;
        ns = (n_smp == 0) ? 1 : (n_smp > 4096) ? 4096 : n_smp;
        kk = k_in;
        if (kk < 0)
            kk = -kk;
        fr = f_in;
        term = fr * longint'(slowness) - (kk <<< 20);
        sum_s = 0;
        sum_c = 0;
        for (int i = 0; i < n; i++)
        begin
            dd = dist_tab[i];
            phv = term * dd;
            sincos(phv[51:20], sn, cs);
            sum_s += sn;
            sum_c += cs;
        end
        step = (fr * longint'(dt)) & 64'hFFFF_FFFF_FFFF;
        acc = 0;
        best = 0;
        for (int i = 0; i < ns; i++)
        begin
            ph = acc;
            sincos(ph[47:16], sn, cs);
            b = sn * sum_c + cs * sum_s;
            if (b < 0)
                b = -b;
            if (b > best)
                best = b;
            acc = (acc + step) & 64'hFFFF_FFFF_FFFF;
        end
        q = best / (n * 32768);
        return (q > 32768) ? 16'd32768 : q[15:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        beam_t want;
        if (!rst_n)
        begin
            n_sta      = pwar_pkg::RST_STATION_COUNT;
            slowness   = pwar_pkg::RST_INV_VELOCITY;
            dt         = pwar_pkg::RST_SAMPLE_INTERVAL;
            n_smp      = pwar_pkg::RST_SAMPLE_COUNT;
            peak_amp   = 16'd0;
            floor_amp  = pwar_pkg::FULL_SCALE;
            beam_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    pwar_pkg::CFG_STATION_COUNT:   n_sta = cfg_data[7:0];
                    pwar_pkg::CFG_INV_VELOCITY:    slowness = cfg_data[23:0];
                    pwar_pkg::CFG_SAMPLE_INTERVAL: dt = cfg_data;
                    pwar_pkg::CFG_SAMPLE_COUNT:    n_smp = cfg_data[12:0];
                endcase
            end
            // score the result transaction against the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (beam_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result amp=%0d max=%0d min=%0d",
                                 amplitude, grid_max, grid_min);
                end
                else
                begin
                    want = beam_q.pop_front();
                    if (want.amp !== amplitude || want.peak !== grid_max
                        || want.floor_amp !== grid_min)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp amp=%0d max=%0d min=%0d, got %0d %0d %0d",
                                     want.amp, want.peak, want.floor_amp,
                                     amplitude, grid_max, grid_min);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (op == pwar_pkg::OP_LOAD)
                    dist_tab[station_index] = distance;
                else
                begin
                    want.amp = beam_peak(wavenumber, frequency);
                    if (want.amp > peak_amp)
                        peak_amp = want.amp;
                    if (want.amp < floor_amp)
                        floor_amp = want.amp;
                    want.peak = peak_amp;
                    want.floor_amp = floor_amp;
                    beam_q.push_back(want);
                end
            end
            pending = beam_q.size();
        end
    end
endmodule

// ----- test/plane_wave_array_response_tb.sv -----
module plane_wave_array_response_tb;

    // Drain time after the last result: a full-size compute plus margin.
    localparam int DRAIN_CYCLES = 4400;
    localparam int HOLD_CYCLES  = 3000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               op;
    logic [6:0]         station_index;
    logic signed [23:0] distance;
    logic signed [23:0] wavenumber;
    logic [23:0]        frequency;
    logic               out_valid;
    logic               out_stall;
    logic [15:0]        amplitude;
    logic [15:0]        grid_max;
    logic [15:0]        grid_min;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;
    int                 fail_count;
    int                 pending;

    // idle percentages for each side; zero gives a stretch at full rate
    int in_idle_pct;
    int out_idle_pct;
    bit hold_req;

    plane_wave_array_response dut (.*);

    plane_wave_array_response_checker scoreboard (.*);

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Hard limit, well beyond the slowest legal run.
    initial
    begin
        #(20 * 3000000);
        $display("plane_wave_array_response_tb failed");
        $finish;
    end

    // Result side: random stall, plus one long hold-off counted here so the
    // block backs up and stalls its input.
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < out_idle_pct);
        end
    end

    // Field value biased toward the extremes.
    function automatic logic [23:0] pick24();
        case ($urandom_range(9))
            0:       return 24'h7F_FFFF;
            1:       return 24'h80_0000;
            2:       return 24'h00_0000;
            3:       return 24'hFF_FFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    // Offer one input transaction and hold it until the block takes it.
    task automatic send(input logic o, input logic [6:0] idx, input logic [23:0] d,
                        input logic [23:0] k, input logic [23:0] f);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            op       <= 1'($urandom);
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        op            <= o;
        station_index <= idx;
        distance      <= d;
        wavenumber    <= k;
        frequency     <= f;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic compute(input logic [23:0] k, input logic [23:0] f);
        send(pwar_pkg::OP_COMPUTE, 7'($urandom), 24'($urandom), k, f);
    endtask

    task automatic load(input logic [6:0] idx, input logic [23:0] d);
        send(pwar_pkg::OP_LOAD, idx, d, 24'($urandom), 24'($urandom));
    endtask

    // Write one register; drop valid between writes so writes never overlap.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Drop input valid, wait for every predicted result, let the block settle.
    task automatic quiesce();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_regs(input logic [7:0] sc, input logic [23:0] iv,
                            input logic [31:0] si, input logic [12:0] ns);
        write_reg(pwar_pkg::CFG_STATION_COUNT, 32'(sc));
        write_reg(pwar_pkg::CFG_INV_VELOCITY, 32'(iv));
        write_reg(pwar_pkg::CFG_SAMPLE_INTERVAL, si);
        write_reg(pwar_pkg::CFG_SAMPLE_COUNT, 32'(ns));
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        op            = pwar_pkg::OP_LOAD;
        station_index = '0;
        distance      = '0;
        wavenumber    = '0;
        frequency     = '0;
        cfg_valid     = 1'b0;
        cfg_index     = pwar_pkg::CFG_STATION_COUNT;
        cfg_data      = '0;
        in_idle_pct   = 20;
        out_idle_pct  = 20;
        hold_req      = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the whole table, distance extremes in the first entries.
        for (int i = 0; i < 128; i++)
            load(i[6:0], (i == 0) ? 24'h7F_FFFF : (i == 1) ? 24'h80_0000 :
                         (i == 2) ? 24'h00_0000 : (i == 3) ? 24'h00_0001 : pick24());

        // Directed: field extremes, with the rate registers at the top of their range.
        compute(24'h00_0000, 24'h00_0000);   // reset defaults, entry 0 only
        quiesce();
        set_regs(8'd4, 24'hFF_FFFF, 32'hFFFF_FFFF, 13'd16);
        compute(24'h7F_FFFF, 24'h00_0000);
        compute(24'h80_0000, 24'hFF_FFFF);
        compute(24'h00_0000, 24'hFF_FFFF);
        compute(24'hFF_FFFF, 24'h00_0001);
        compute(24'h00_0001, 24'h01_0000);
        quiesce();
        // zero counts act as one, zero rates
        set_regs(8'd0, 24'h00_0000, 32'h0000_0000, 13'd0);
        compute(24'h00_0000, 24'h00_0000);
        compute(24'h80_0000, 24'hFF_FFFF);
        compute(24'($urandom), 24'($urandom));
        quiesce();

        // Largest sizes a few times.
        set_regs(8'd255, 24'($urandom), $urandom, 13'd8191);
        compute(pick24(), pick24());
        compute(pick24(), pick24());
        quiesce();
        set_regs(8'd128, 24'($urandom), $urandom, 13'd4096);
        compute(pick24(), pick24());
        quiesce();

        // Random phases with small sample counts; one without idling, one
        // with the long result hold-off and computes only.
        for (int ph = 0; ph < 5; ph++)
        begin
            in_idle_pct  = (ph == 2) ? 0 : 20;
            out_idle_pct = (ph == 2) ? 0 : 20;
            set_regs(8'($urandom_range(1, 128)), pick24(), $urandom,
                     13'($urandom_range(1, 32)));
            if (ph == 3)
                hold_req = 1;
            for (int j = 0; j < 3; j++)
            begin
                if (ph != 3 && $urandom_range(99) < 20)
                    load(7'($urandom), pick24());
                else
                    compute(pick24(), pick24());
            end
            quiesce();
        end

        if (fail_count == 0 && pending == 0)
            $display("plane_wave_array_response_tb passed");
        else
            $display("plane_wave_array_response_tb failed");
        $finish;
    end
endmodule
